// ----- src/smm_pkg.sv -----
// Shared types for the square matrix multiplier.
`timescale 1ns / 1ps

package smm_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int IDX_W  = 3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } t_state;

    // Operand token handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic signed [ELEM_W-1:0] a;
    } t_tok;

endpackage

// ----- src/smm_cell.sv -----
// One multiply-accumulate cell: holds a column of the second matrix.
`timescale 1ns / 1ps

module smm_cell
    import smm_pkg::*;
#(
    parameter int DIM = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tok                     i_tok,
    output t_tok                     o_tok,
    input  logic                     i_wr_en,
    input  logic [((DIM > 1) ? $clog2(DIM) : 1)-1:0] i_wr_row,
    input  logic signed [ELEM_W-1:0] i_wr_data,
    output logic signed [ACC_W-1:0]  o_acc,
    output logic                     o_done
);

    localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(DIM - 1);

    logic signed [ELEM_W-1:0] r_col [DIM];
    logic [KW-1:0]            r_k;
    t_tok                     r_tok;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvalid;
    logic                     r_pfirst;
    logic                     r_plast;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    // column store, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_col[i_wr_row] <= i_wr_data;
        end
    end

    // token pass-through, k tracking, valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_k      <= '0;
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_tok    <= i_tok;
            r_pvalid <= i_tok.valid;
            r_done   <= r_pvalid && r_plast;
            if (i_tok.valid) begin
                r_k <= (r_k == K_LAST) ? '0 : r_k + 1'b1;
            end
        end
    end

    // multiply stage then accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_prod   <= PROD_W'(i_tok.a) * PROD_W'(r_col[r_k]);
            r_pfirst <= (r_k == '0);
            r_plast  <= (r_k == K_LAST);
        end
        if (r_pvalid) begin
            r_acc <= r_pfirst ? {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod}
                              : r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    assign o_tok  = r_tok;
    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ----- src/square_matrix_multiply.sv -----
// Top level: operand loading, sequencer, cell chain and result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_element_value, i_to_second
//  out     | source    | o_out_valid / i_out_stall  | o_product_value, o_out_row,
//          |           |                            | o_out_col, o_last_element
//  cfg     | sink      | i_cfg_we                   | i_cfg_data (transpose_first)
//
// Loading takes one beat per cycle. The beat that fills both matrices starts a
// product run: per row, one first-matrix read per k, a wait on the cell chain
// until the last cell's done pulse, then DIM result beats, each held while the
// output stalls. The single read port of the first-matrix memory sets the issue
// rate. Input is stalled for the whole run.
// Reset is synchronous, active low: fill counts, sequencer, output valid and the
// transpose bit clear; matrix stores are not cleared.
// A stalled result holds in the output register; a waiting result does not
// hold off new input beats once the run has ended.
`timescale 1ns / 1ps

module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int DIM = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  logic                     i_to_second,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [ACC_W-1:0]  o_product_value,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic                     o_last_element
);

    localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW = $clog2(DIM * DIM);
    localparam logic [KW-1:0] LAST = KW'(DIM - 1);

    // configuration
    logic r_transpose;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose <= 1'b0;
        end else if (i_cfg_we) begin
            r_transpose <= i_cfg_data;
        end
    end

    // sequencer state
    t_state        r_state, n_state;
    logic [KW-1:0] r_row, n_row;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_col, n_col;

    // fill tracking, row/column counters per matrix
    logic [KW-1:0] r_a_row, r_a_col, r_b_row, r_b_col;
    logic          r_a_full, r_b_full;
    logic          w_accept, w_a_take, w_b_take;
    logic          w_a_full_n, w_b_full_n, w_complete;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_a_take   = w_accept && !i_to_second && !r_a_full;
    assign w_b_take   = w_accept && i_to_second && !r_b_full;
    assign w_a_full_n = r_a_full || (w_a_take && r_a_row == LAST && r_a_col == LAST);
    assign w_b_full_n = r_b_full || (w_b_take && r_b_row == LAST && r_b_col == LAST);
    assign w_complete = w_accept && w_a_full_n && w_b_full_n;

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_row  <= '0;
            r_a_col  <= '0;
            r_a_full <= 1'b0;
            r_b_row  <= '0;
            r_b_col  <= '0;
            r_b_full <= 1'b0;
        end else if (w_complete) begin
            r_a_row  <= '0;
            r_a_col  <= '0;
            r_a_full <= 1'b0;
            r_b_row  <= '0;
            r_b_col  <= '0;
            r_b_full <= 1'b0;
        end else begin
            if (w_a_take) begin
                if (r_a_col == LAST) begin
                    r_a_col <= '0;
                    if (r_a_row == LAST) begin
                        r_a_full <= 1'b1;
                    end else begin
                        r_a_row <= r_a_row + 1'b1;
                    end
                end else begin
                    r_a_col <= r_a_col + 1'b1;
                end
            end
            if (w_b_take) begin
                if (r_b_col == LAST) begin
                    r_b_col <= '0;
                    if (r_b_row == LAST) begin
                        r_b_full <= 1'b1;
                    end else begin
                        r_b_row <= r_b_row + 1'b1;
                    end
                end else begin
                    r_b_col <= r_b_col + 1'b1;
                end
            end
        end
    end

    // first matrix memory, row-major; one write and one registered read
    logic signed [ELEM_W-1:0] r_a_mem [DIM*DIM];
    logic signed [ELEM_W-1:0] r_rd_data;
    logic                     r_rd_valid;
    logic                     w_rd_en;
    logic [AW-1:0]            w_wr_addr, w_rd_addr;

    assign w_wr_addr = AW'(r_a_row * DIM + r_a_col);
    // transpose reads A[k][row] instead of A[row][k]
    assign w_rd_addr = r_transpose ? AW'(r_k * DIM + r_row) : AW'(r_row * DIM + r_k);

    always_ff @(posedge i_clk) begin
        if (w_a_take) begin
            r_a_mem[w_wr_addr] <= i_element_value;
        end
        r_rd_data <= r_a_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_rd_en;
        end
    end

    // cell chain: cell j owns column j of the second matrix
    t_tok                    w_tok [DIM];
    logic signed [ACC_W-1:0] w_acc [DIM];
    logic                    w_done;

    assign w_tok[0] = '{valid: r_rd_valid, a: r_rd_data};

    for (genvar j = 0; j < DIM; j++) begin : g_cell
        if (j < DIM - 1) begin : g_mid
            smm_cell #(.DIM(DIM)) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_tok     (w_tok[j]),
                .o_tok     (w_tok[j+1]),
                .i_wr_en   (w_b_take && (r_b_col == KW'(j))),
                .i_wr_row  (r_b_row),
                .i_wr_data (i_element_value),
                .o_acc     (w_acc[j]),
                .o_done    ()
            );
        end else begin : g_end
            // last cell finishes last; its done pulse closes the row
            smm_cell #(.DIM(DIM)) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_tok     (w_tok[j]),
                .o_tok     (),
                .i_wr_en   (w_b_take && (r_b_col == KW'(j))),
                .i_wr_row  (r_b_row),
                .i_wr_data (i_element_value),
                .o_acc     (w_acc[j]),
                .o_done    (w_done)
            );
        end
    end

    // output register
    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_value;
    logic [IDX_W-1:0]        r_out_row, r_out_col;
    logic                    r_out_last;
    logic                    w_out_load;

    assign w_out_load = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value <= w_acc[r_col];
            r_out_row   <= IDX_W'(r_row);
            r_out_col   <= IDX_W'(r_col);
            r_out_last  <= (r_row == LAST) && (r_col == LAST);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_product_value = r_out_value;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_last_element  = r_out_last;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_k     <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_k     <= n_k;
            r_col   <= n_col;
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_k     = r_k;
        n_col   = r_col;
        w_rd_en = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_complete) begin
                    n_state = ST_ISSUE;
                    n_row   = '0;
                    n_k     = '0;
                end
            end
            ST_ISSUE: begin
                w_rd_en = 1'b1;
                if (r_k == LAST) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = ST_EMIT;
                    n_col   = '0;
                end
            end
            ST_EMIT: begin
                if (w_out_load) begin
                    if (r_col == LAST) begin
                        n_col = '0;
                        if (r_row == LAST) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_row   = r_row + 1'b1;
                            n_state = ST_ISSUE;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
